// ===== rtl/core/tmi_pkg.sv =====
// tmi_pkg: sizes, command and opcode codes, and the structs shared by the
// tape machine interpreter modules. No dependencies.
`default_nettype none

package tmi_pkg;

   localparam int PROG_DEPTH = 4096;
   localparam int TAPE_CELLS = 32768;

   // program address, program counter (holds PROG_DEPTH itself), cell pointer
   localparam int PA_W  = $clog2(PROG_DEPTH);
   localparam int PC_W  = PA_W + 1;
   localparam int CP_W  = (TAPE_CELLS > 1) ? $clog2(TAPE_CELLS) : 1;
   localparam int ALU_W = (CP_W > PC_W) ? ((CP_W > 8) ? CP_W : 8)
                                        : ((PC_W > 8) ? PC_W : 8);

   // fixed field widths of the transactions
   localparam int OPC_W    = 2;
   localparam int ADDR_W   = 12;
   localparam int LEN_W    = 13;
   localparam int PCNOW_W  = 13;
   localparam int REQ_DW   = 32;
   localparam int RSP_DW   = 24;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   localparam logic [CSR_AW-1:0] CSR_PROG_LEN = 3'd0;

   localparam logic [OPC_W-1:0] OP_LOAD    = 2'd0;
   localparam logic [OPC_W-1:0] OP_STEP    = 2'd1;
   localparam logic [OPC_W-1:0] OP_RESTART = 2'd2;

   localparam logic [7:0] CMD_RIGHT = 8'h3E;
   localparam logic [7:0] CMD_LEFT  = 8'h3C;
   localparam logic [7:0] CMD_INC   = 8'h2B;
   localparam logic [7:0] CMD_DEC   = 8'h2D;
   localparam logic [7:0] CMD_OUT   = 8'h2E;
   localparam logic [7:0] CMD_IN    = 8'h2C;
   localparam logic [7:0] CMD_OPEN  = 8'h5B;
   localparam logic [7:0] CMD_CLOSE = 8'h5D;

   typedef struct packed {
      logic [OPC_W-1:0]  opcode;
      logic [ADDR_W-1:0] prog_addr;
      logic [7:0]        prog_byte;
      logic              in_valid;
      logic [7:0]        in_byte;
   } item_type;

   typedef struct packed {
      logic               out_valid;
      logic [7:0]         out_byte;
      logic               input_taken;
      logic               halted;
      logic [PCNOW_W-1:0] pc_now;
   } result_type;

   typedef enum logic {
      ALU_INC = 1'b0,
      ALU_DEC = 1'b1
   } alu_op_type;

   typedef struct packed {
      alu_op_type       op;
      logic [ALU_W-1:0] a;
      logic [ALU_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [ALU_W-1:0] sum;
      logic             eq;
   } alu_rsp_type;

endpackage

`default_nettype wire

// ===== rtl/core/tmi_alu.sv =====
// tmi_alu: shared increment/decrement unit with a compare against a limit.
// Depends on tmi_pkg.
`default_nettype none

module tmi_alu (
   input  tmi_pkg::alu_req_type req,
   output tmi_pkg::alu_rsp_type rsp
);

   logic [tmi_pkg::ALU_W-1:0] sum;

   always_comb begin
      case (req.op)
         tmi_pkg::ALU_INC: sum = req.a + tmi_pkg::ALU_W'(1);
         tmi_pkg::ALU_DEC: sum = req.a - tmi_pkg::ALU_W'(1);
         default:          sum = req.a;
      endcase
   end

   assign rsp.sum = sum;
   assign rsp.eq  = (sum == req.b);

endmodule

`default_nettype wire

// ===== rtl/core/tmi_engine.sv =====
// tmi_engine: sequencer, program store, tape store and machine state.
// Counting goes through the shared tmi_alu, except the bracket depth. Depends on tmi_pkg.
`default_nettype none

module tmi_engine (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   input  tmi_pkg::item_type            item,
   input  wire [tmi_pkg::LEN_W-1:0]     prog_len,
   output logic                         ready,
   output logic                         res_valid,
   input  wire                          out_free,
   output tmi_pkg::result_type          result,
   output tmi_pkg::alu_req_type         alu_req,
   input  tmi_pkg::alu_rsp_type         alu_rsp
);

   localparam int PA_W = tmi_pkg::PA_W;
   localparam int PC_W = tmi_pkg::PC_W;
   localparam int CP_W = tmi_pkg::CP_W;
   localparam int AW   = tmi_pkg::ALU_W;

   typedef enum logic [7:0] {
      ST_CLEAR   = 8'b0000_0001,
      ST_IDLE    = 8'b0000_0010,
      ST_ZSCAN   = 8'b0000_0100,
      ST_EXEC    = 8'b0000_1000,
      ST_SCAN    = 8'b0001_0000,
      ST_ADVANCE = 8'b0010_0000,
      ST_DONE    = 8'b0100_0000,
      ST_SPARE   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [PC_W-1:0] pc_ff, pc_in;
   logic [CP_W-1:0] cp_ff, cp_in;
   logic [CP_W-1:0] hwm_ff, hwm_in;
   logic [PC_W-1:0] fz_ff, fz_in;
   logic [PC_W-1:0] scan_ff, scan_in;
   logic [PC_W-1:0] depth_ff, depth_in;
   logic            fwd_ff, fwd_in;
   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_byte_ff, in_byte_in;
   logic            ov_ff, ov_in;
   logic [7:0]      ob_ff, ob_in;
   logic            it_ff, it_in;

   logic [7:0]      prog_mem [tmi_pkg::PROG_DEPTH];
   logic [7:0]      prog_q_ff;
   logic            prog_we;
   logic [PA_W-1:0] prog_waddr, prog_raddr;
   logic [7:0]      prog_wdata;

   logic [7:0]      tape_mem [tmi_pkg::TAPE_CELLS];
   logic [7:0]      tape_q_ff;
   logic            tape_we;
   logic [CP_W-1:0] tape_waddr, tape_raddr;
   logic [7:0]      tape_wdata;

   logic [PC_W-1:0] lim_w, end_w, depth_nx;
   logic [PC_W-1:0] load_addr;

   always_ff @(posedge clock) begin
      if (prog_we) begin
         prog_mem[prog_waddr] <= prog_wdata;
      end
      prog_q_ff <= prog_mem[prog_raddr];
   end

   always_ff @(posedge clock) begin
      if (tape_we) begin
         tape_mem[tape_waddr] <= tape_wdata;
      end
      tape_q_ff <= tape_mem[tape_raddr];
   end

   // end of program: least of length, depth and first zero byte
   always_comb begin
      if (32'(prog_len) >= 32'(tmi_pkg::PROG_DEPTH)) begin
         lim_w = PC_W'(tmi_pkg::PROG_DEPTH);
      end else begin
         lim_w = PC_W'(prog_len);
      end
      end_w = (fz_ff < lim_w) ? fz_ff : lim_w;
   end

   assign load_addr = PC_W'(item.prog_addr);

   // nesting depth after the byte under the scan pointer
   always_comb begin
      depth_nx = depth_ff;
      if (prog_q_ff == (fwd_ff ? tmi_pkg::CMD_OPEN : tmi_pkg::CMD_CLOSE)) begin
         depth_nx = depth_ff + PC_W'(1);
      end else if (prog_q_ff == (fwd_ff ? tmi_pkg::CMD_CLOSE : tmi_pkg::CMD_OPEN)) begin
         depth_nx = depth_ff - PC_W'(1);
      end
   end

   always_comb begin
      state_in    = state_ff;
      pc_in       = pc_ff;
      cp_in       = cp_ff;
      hwm_in      = hwm_ff;
      fz_in       = fz_ff;
      scan_in     = scan_ff;
      depth_in    = depth_ff;
      fwd_in      = fwd_ff;
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      ov_in       = ov_ff;
      ob_in       = ob_ff;
      it_in       = it_ff;
      prog_we     = 1'b0;
      prog_waddr  = PA_W'(item.prog_addr);
      prog_wdata  = item.prog_byte;
      prog_raddr  = pc_ff[PA_W-1:0];
      tape_we     = 1'b0;
      tape_waddr  = cp_ff;
      tape_wdata  = 8'h00;
      tape_raddr  = cp_ff;
      alu_req.op  = tmi_pkg::ALU_INC;
      alu_req.a   = '0;
      alu_req.b   = '0;
      res_valid   = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            // one program byte a cycle; cell 0 is the only live tape cell
            prog_we    = 1'b1;
            prog_waddr = scan_ff[PA_W-1:0];
            prog_wdata = 8'h00;
            tape_we    = 1'b1;
            tape_waddr = '0;
            alu_req.a  = AW'(scan_ff);
            alu_req.b  = AW'(tmi_pkg::PROG_DEPTH);
            scan_in    = alu_rsp.sum[PC_W-1:0];
            if (alu_rsp.eq) begin
               fz_in    = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               ov_in       = 1'b0;
               ob_in       = 8'h00;
               it_in       = 1'b0;
               in_valid_in = item.in_valid;
               in_byte_in  = item.in_byte;
               state_in    = ST_DONE;
               case (item.opcode)
                  tmi_pkg::OP_LOAD: begin
                     if (32'(item.prog_addr) < 32'(tmi_pkg::PROG_DEPTH)) begin
                        prog_we = 1'b1;
                        if (item.prog_byte == 8'h00 && load_addr < fz_ff) begin
                           fz_in = load_addr;
                        end else if (item.prog_byte != 8'h00 && load_addr == fz_ff) begin
                           // first zero overwritten: look for the next one
                           alu_req.a = AW'(load_addr);
                           alu_req.b = AW'(tmi_pkg::PROG_DEPTH);
                           if (alu_rsp.eq) begin
                              fz_in = PC_W'(tmi_pkg::PROG_DEPTH);
                           end else begin
                              prog_raddr = alu_rsp.sum[PA_W-1:0];
                              scan_in    = alu_rsp.sum[PC_W-1:0];
                              state_in   = ST_ZSCAN;
                           end
                        end
                     end
                  end
                  tmi_pkg::OP_STEP: begin
                     if (pc_ff < end_w) begin
                        state_in = ST_EXEC;
                     end
                  end
                  tmi_pkg::OP_RESTART: begin
                     pc_in      = '0;
                     cp_in      = '0;
                     hwm_in     = '0;
                     tape_we    = 1'b1;
                     tape_waddr = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ZSCAN: begin
            if (prog_q_ff == 8'h00) begin
               fz_in    = scan_ff;
               state_in = ST_DONE;
            end else begin
               alu_req.a = AW'(scan_ff);
               alu_req.b = AW'(tmi_pkg::PROG_DEPTH);
               if (alu_rsp.eq) begin
                  fz_in    = PC_W'(tmi_pkg::PROG_DEPTH);
                  state_in = ST_DONE;
               end else begin
                  prog_raddr = alu_rsp.sum[PA_W-1:0];
                  scan_in    = alu_rsp.sum[PC_W-1:0];
               end
            end
         end
         ST_EXEC: begin
            scan_in  = pc_ff;
            state_in = ST_ADVANCE;
            case (prog_q_ff)
               tmi_pkg::CMD_RIGHT: begin
                  if (32'(cp_ff) < 32'(tmi_pkg::TAPE_CELLS - 1)) begin
                     alu_req.a = AW'(cp_ff);
                     cp_in     = alu_rsp.sum[CP_W-1:0];
                     // first visit of a cell since restart: zero it
                     if (cp_ff == hwm_ff) begin
                        tape_we    = 1'b1;
                        tape_waddr = alu_rsp.sum[CP_W-1:0];
                        hwm_in     = alu_rsp.sum[CP_W-1:0];
                     end
                  end
               end
               tmi_pkg::CMD_LEFT: begin
                  if (cp_ff != '0) begin
                     alu_req.op = tmi_pkg::ALU_DEC;
                     alu_req.a  = AW'(cp_ff);
                     cp_in      = alu_rsp.sum[CP_W-1:0];
                  end
               end
               tmi_pkg::CMD_INC: begin
                  alu_req.a  = AW'(tape_q_ff);
                  tape_we    = 1'b1;
                  tape_wdata = alu_rsp.sum[7:0];
               end
               tmi_pkg::CMD_DEC: begin
                  alu_req.op = tmi_pkg::ALU_DEC;
                  alu_req.a  = AW'(tape_q_ff);
                  tape_we    = 1'b1;
                  tape_wdata = alu_rsp.sum[7:0];
               end
               tmi_pkg::CMD_OUT: begin
                  ov_in = 1'b1;
                  ob_in = tape_q_ff;
               end
               tmi_pkg::CMD_IN: begin
                  if (in_valid_ff) begin
                     tape_we    = 1'b1;
                     tape_wdata = in_byte_ff;
                     it_in      = 1'b1;
                  end
               end
               tmi_pkg::CMD_OPEN: begin
                  if (tape_q_ff == 8'h00) begin
                     alu_req.a = AW'(pc_ff);
                     alu_req.b = AW'(end_w);
                     if (!alu_rsp.eq) begin
                        prog_raddr = alu_rsp.sum[PA_W-1:0];
                        scan_in    = alu_rsp.sum[PC_W-1:0];
                        depth_in   = PC_W'(1);
                        fwd_in     = 1'b1;
                        state_in   = ST_SCAN;
                     end
                  end
               end
               tmi_pkg::CMD_CLOSE: begin
                  if (tape_q_ff != 8'h00 && pc_ff != '0) begin
                     alu_req.op = tmi_pkg::ALU_DEC;
                     alu_req.a  = AW'(pc_ff);
                     prog_raddr = alu_rsp.sum[PA_W-1:0];
                     scan_in    = alu_rsp.sum[PC_W-1:0];
                     depth_in   = PC_W'(1);
                     fwd_in     = 1'b0;
                     state_in   = ST_SCAN;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_SCAN: begin
            depth_in   = depth_nx;
            alu_req.op = fwd_ff ? tmi_pkg::ALU_INC : tmi_pkg::ALU_DEC;
            alu_req.a  = AW'(scan_ff);
            alu_req.b  = AW'(end_w);
            if (depth_nx == '0 || (fwd_ff && alu_rsp.eq) || (!fwd_ff && scan_ff == '0)) begin
               state_in = ST_ADVANCE;
            end else begin
               prog_raddr = alu_rsp.sum[PA_W-1:0];
               scan_in    = alu_rsp.sum[PC_W-1:0];
            end
         end
         ST_ADVANCE: begin
            alu_req.a = AW'(scan_ff);
            pc_in     = alu_rsp.sum[PC_W-1:0];
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            res_valid = 1'b1;
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         pc_ff    <= '0;
         cp_ff    <= '0;
         hwm_ff   <= '0;
         fz_ff    <= '0;
         scan_ff  <= '0;
         depth_ff <= '0;
         fwd_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         cp_ff    <= cp_in;
         hwm_ff   <= hwm_in;
         fz_ff    <= fz_in;
         scan_ff  <= scan_in;
         depth_ff <= depth_in;
         fwd_ff   <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      in_valid_ff <= in_valid_in;
      in_byte_ff  <= in_byte_in;
      ov_ff       <= ov_in;
      ob_ff       <= ob_in;
      it_ff       <= it_in;
   end

   assign ready              = (state_ff == ST_IDLE);
   assign result.out_valid   = ov_ff;
   assign result.out_byte    = ob_ff;
   assign result.input_taken = it_ff;
   assign result.halted      = (pc_ff >= end_w);
   assign result.pc_now      = tmi_pkg::PCNOW_W'(pc_ff);

   // every cell up to the high-water mark has been written since restart
   a_cp_below_hwm: assert property (@(posedge clock) disable iff (reset)
      cp_ff <= hwm_ff)
      else $error("cell pointer above high-water mark");

   a_tape_write_range: assert property (@(posedge clock) disable iff (reset)
      tape_we |-> (32'(tape_waddr) <= 32'(hwm_ff) + 32'd1))
      else $error("tape write beyond first unvisited cell");

   a_fz_range: assert property (@(posedge clock) disable iff (reset)
      32'(fz_ff) <= 32'(tmi_pkg::PROG_DEPTH))
      else $error("first zero index out of range");

   a_start_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> (state_ff == ST_IDLE) ##1 (state_ff != ST_IDLE))
      else $error("transaction started outside idle");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && !out_free) |=> (state_ff == ST_DONE) && $stable(pc_ff))
      else $error("result dropped while output busy");

endmodule

`default_nettype wire

// ===== rtl/core/tape_machine_interpreter_core.sv =====
// tape_machine_interpreter_core: top level with stream ports, APB register
// and output register around tmi_engine and tmi_alu. Depends on tmi_pkg.
//
//   channel   ports     direction   content
//   req       req_t*    in          load / step / restart transactions
//   rsp       rsp_t*    out         one result per request transaction
//   csr       csr_p*    in/out      program_length at byte address 0
//
// After reset the program store is cleared, one byte a cycle, with
// req_tready low; csr writes are taken throughout.
// A step goes through read, execute, counter update and hand-over in the engine,
// with a bracket scan walking program bytes between execute and counter update.
// Load, restart, the unused opcode and a step on a halted machine go from idle
// straight to hand-over; a load that overwrites the first zero byte walks the
// program store forward to find the next one, one byte a cycle.
// The store read port and the shared increment unit set this sequence.
// A result waits in the output register; the engine stalls only when a
// second result is ready before the first is taken.
`default_nettype none

module tape_machine_interpreter_core (
   input  wire                          clock,
   input  wire                          reset,
   // [11:0] prog_addr, [19:12] prog_byte, [20] in_valid, [28:21] in_byte
   input  wire [tmi_pkg::REQ_DW-1:0]    req_tdata,
   // [1:0] opcode
   input  wire [tmi_pkg::OPC_W-1:0]     req_tuser,
   input  wire                          req_tvalid,
   output logic                         req_tready,
   // [0] out_valid, [8:1] out_byte, [9] input_taken, [10] halted, [23:11] pc_now
   output logic [tmi_pkg::RSP_DW-1:0]   rsp_tdata,
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   input  wire                          csr_psel,
   input  wire                          csr_penable,
   input  wire                          csr_pwrite,
   input  wire [tmi_pkg::CSR_AW-1:0]    csr_paddr,
   input  wire [tmi_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [tmi_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                         csr_pready
);

   logic [tmi_pkg::LEN_W-1:0]  len_ff, len_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [tmi_pkg::RSP_DW-1:0] rsp_data_ff, rsp_data_in;

   tmi_pkg::item_type     item;
   tmi_pkg::result_type   result;
   tmi_pkg::alu_req_type  alu_req;
   tmi_pkg::alu_rsp_type  alu_rsp;
   logic                  eng_ready;
   logic                  res_valid;
   logic                  out_free;
   logic                  start;
   logic                  csr_wr;
   logic                  csr_hit;

   assign item.prog_addr = req_tdata[11:0];
   assign item.prog_byte = req_tdata[19:12];
   assign item.in_valid  = req_tdata[20];
   assign item.in_byte   = req_tdata[28:21];
   assign item.opcode    = req_tuser;

   assign req_tready = eng_ready;
   assign start      = req_tvalid && eng_ready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   tmi_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   tmi_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .item      (item),
      .prog_len  (len_ff),
      .ready     (eng_ready),
      .res_valid (res_valid),
      .out_free  (out_free),
      .result    (result),
      .alu_req   (alu_req),
      .alu_rsp   (alu_rsp)
   );

   // byte offset bits are ignored: register index is paddr / 4
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[tmi_pkg::CSR_AW-1:2] == tmi_pkg::CSR_PROG_LEN[tmi_pkg::CSR_AW-1:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign len_in     = (csr_wr && csr_hit) ? csr_pwdata[tmi_pkg::LEN_W-1:0] : len_ff;
   assign csr_prdata = csr_hit ? tmi_pkg::CSR_DW'(len_ff) : '0;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {result.pc_now, result.halted, result.input_taken,
                         result.out_byte, result.out_valid};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire
